// ===== hdl/nst_pkg.sv =====
// Shared types and constants for the named semaphore table.
// Used by nst_store, nst_ctrl and named_semaphore_table; no dependencies.
package nst_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int NAME_BYTES  = 8;
    localparam int NAME_W      = 8 * NAME_BYTES;
    localparam int KEY_W       = 64;
    localparam int CNT_W       = 16;
    localparam int INIT_W      = 15;
    localparam int OUT_IDX_W   = 6;
    localparam int EXT_W       = IDX_W + OUT_IDX_W + 1;

    localparam logic signed [CNT_W-1:0] CNT_MAX = {1'b0, {(CNT_W-1){1'b1}}};
    localparam logic signed [CNT_W-1:0] CNT_MIN = {1'b1, {(CNT_W-1){1'b0}}};

    typedef enum logic [1:0] {
        MODE_OPEN   = 2'd0,
        MODE_WAIT   = 2'd1,
        MODE_POST   = 2'd2,
        MODE_REMOVE = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_NOTFOUND = 2'd1,
        STAT_FULL     = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ,
        ST_MODIFY,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]        mode;
        logic [KEY_W-1:0]  name_key;
        logic [INIT_W-1:0] init_value;
        logic [5:0]        sem_index;
    } t_in;

    typedef struct packed {
        logic [1:0]               status;
        logic [OUT_IDX_W-1:0]     slot_index;
        logic                     must_block;
        logic                     wake_waiter;
        logic signed [CNT_W-1:0]  new_count;
    } t_out;

    typedef struct packed {
        logic                    rd_en;
        logic [IDX_W-1:0]        rd_addr;
        logic                    wr_name_en;
        logic                    wr_cnt_en;
        logic [IDX_W-1:0]        wr_addr;
        logic [NAME_W-1:0]       wr_name;
        logic signed [CNT_W-1:0] wr_cnt;
    } t_mem_req;

    typedef struct packed {
        logic [NAME_W-1:0]       name;
        logic signed [CNT_W-1:0] cnt;
    } t_mem_rsp;

    // Slot number to the six-bit result field: only the low bits are carried.
    function automatic logic [OUT_IDX_W-1:0] to_out_idx(input logic [IDX_W-1:0] a);
        logic [IDX_W+OUT_IDX_W-1:0] ext;
        ext = {{OUT_IDX_W{1'b0}}, a};
        return ext[OUT_IDX_W-1:0];
    endfunction

endpackage

// ===== hdl/nst_store.sv =====
// Name and count memories of the semaphore table, one shared read port.
// Depends on nst_pkg.
module nst_store (
    input  logic             i_clk,
    input  nst_pkg::t_mem_req i_req,
    output nst_pkg::t_mem_rsp o_rsp
);
    import nst_pkg::*;

    logic [NAME_W-1:0]       mem_name [TABLE_DEPTH];
    logic signed [CNT_W-1:0] mem_cnt  [TABLE_DEPTH];
    logic [NAME_W-1:0]       r_rd_name;
    logic signed [CNT_W-1:0] r_rd_cnt;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_name_en) begin
            mem_name[i_req.wr_addr] <= i_req.wr_name;
        end
        if (i_req.wr_cnt_en) begin
            mem_cnt[i_req.wr_addr] <= i_req.wr_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_name <= mem_name[i_req.rd_addr];
            r_rd_cnt  <= mem_cnt[i_req.rd_addr];
        end
    end

    assign o_rsp.name = r_rd_name;
    assign o_rsp.cnt  = r_rd_cnt;

endmodule

// ===== hdl/nst_ctrl.sv =====
// Sequencer of the semaphore table: name scan, count update and valid bits.
// Depends on nst_pkg; drives the memories in nst_store.
module nst_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  nst_pkg::t_in      i_in,
    output logic              o_busy,
    input  logic              i_res_free,
    output logic              o_res_push,
    output nst_pkg::t_out     o_res,
    output nst_pkg::t_mem_req o_req,
    input  nst_pkg::t_mem_rsp i_rsp
);
    import nst_pkg::*;

    t_state                  r_state, n_state;
    logic [1:0]              r_mode, n_mode;
    logic [NAME_W-1:0]       r_key, n_key;
    logic [INIT_W-1:0]       r_init, n_init;
    logic [IDX_W-1:0]        r_idx, n_idx;
    logic [IDX_W:0]          r_addr, n_addr;
    logic                    r_pend, n_pend;
    logic [IDX_W-1:0]        r_paddr, n_paddr;
    logic                    r_free_vld, n_free_vld;
    logic [IDX_W-1:0]        r_free, n_free;
    logic [TABLE_DEPTH-1:0]  r_valid, n_valid;
    t_out                    r_res, n_res;

    logic                    in_acc;
    logic [EXT_W-1:0]        idx_ext;
    logic [IDX_W-1:0]        idx_addr;
    logic                    idx_ok;
    logic                    hit;
    logic                    scan_last;
    logic                    free_now;
    logic [IDX_W-1:0]        free_addr;
    logic signed [CNT_W-1:0] cnt_upd;

    assign in_acc   = i_in_valid && (r_state == ST_IDLE);
    assign idx_ext  = EXT_W'(i_in.sem_index);
    assign idx_addr = idx_ext[IDX_W-1:0];
    assign idx_ok   = (idx_ext < EXT_W'(TABLE_DEPTH)) && r_valid[idx_addr];

    // A compare is due for the slot read in the previous cycle.
    assign hit       = r_pend && r_valid[r_paddr] && (i_rsp.name == r_key);
    assign scan_last = r_pend && (r_paddr == IDX_W'(TABLE_DEPTH - 1));
    assign free_now  = r_free_vld || (r_pend && !r_valid[r_paddr]);
    assign free_addr = r_free_vld ? r_free : r_paddr;

    always_comb begin
        cnt_upd = i_rsp.cnt;
        if (r_mode == MODE_WAIT) begin
            if (i_rsp.cnt != CNT_MIN) begin
                cnt_upd = i_rsp.cnt - CNT_W'(1);
            end
        end else begin
            if (i_rsp.cnt != CNT_MAX) begin
                cnt_upd = i_rsp.cnt + CNT_W'(1);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_in.mode == MODE_OPEN || i_in.mode == MODE_REMOVE) begin
                        n_state = ST_SCAN;
                    end else if (idx_ok) begin
                        n_state = ST_READ;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                if (hit || scan_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_READ:   n_state = ST_MODIFY;
            ST_MODIFY: n_state = ST_DONE;
            ST_DONE: begin
                if (i_res_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_mode     = r_mode;
        n_key      = r_key;
        n_init     = r_init;
        n_idx      = r_idx;
        n_addr     = r_addr;
        n_pend     = 1'b0;
        n_paddr    = r_paddr;
        n_free_vld = r_free_vld;
        n_free     = r_free;
        n_valid    = r_valid;
        n_res      = r_res;
        o_req      = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_mode     = i_in.mode;
                    n_key      = i_in.name_key[NAME_W-1:0];
                    n_init     = i_in.init_value;
                    n_idx      = idx_addr;
                    n_addr     = '0;
                    n_free_vld = 1'b0;
                    // Result for a wait or post on a slot that is not in use.
                    n_res.status      = STAT_NOTFOUND;
                    n_res.slot_index  = i_in.sem_index;
                    n_res.must_block  = 1'b0;
                    n_res.wake_waiter = 1'b0;
                    n_res.new_count   = '0;
                end
            end
            ST_SCAN: begin
                if (r_addr < (IDX_W+1)'(TABLE_DEPTH)) begin
                    o_req.rd_en   = 1'b1;
                    o_req.rd_addr = r_addr[IDX_W-1:0];
                    n_pend        = 1'b1;
                    n_paddr       = r_addr[IDX_W-1:0];
                    n_addr        = r_addr + (IDX_W+1)'(1);
                end
                n_free_vld = free_now;
                n_free     = free_addr;
                n_res.must_block  = 1'b0;
                n_res.wake_waiter = 1'b0;
                if (hit) begin
                    n_res.status     = STAT_OK;
                    n_res.slot_index = to_out_idx(r_paddr);
                    if (r_mode == MODE_OPEN) begin
                        n_res.new_count = i_rsp.cnt;
                    end else begin
                        n_res.new_count    = '0;
                        n_valid[r_paddr]   = 1'b0;
                    end
                end else if (scan_last) begin
                    n_res.new_count  = '0;
                    n_res.slot_index = '0;
                    if (r_mode == MODE_REMOVE) begin
                        n_res.status = STAT_NOTFOUND;
                    end else if (free_now) begin
                        o_req.wr_name_en   = 1'b1;
                        o_req.wr_cnt_en    = 1'b1;
                        o_req.wr_addr      = free_addr;
                        o_req.wr_name      = r_key;
                        o_req.wr_cnt       = {1'b0, r_init};
                        n_valid[free_addr] = 1'b1;
                        n_res.status       = STAT_OK;
                        n_res.slot_index   = to_out_idx(free_addr);
                        n_res.new_count    = {1'b0, r_init};
                    end else begin
                        n_res.status = STAT_FULL;
                    end
                end
            end
            ST_READ: begin
                o_req.rd_en   = 1'b1;
                o_req.rd_addr = r_idx;
            end
            ST_MODIFY: begin
                o_req.wr_cnt_en   = 1'b1;
                o_req.wr_addr     = r_idx;
                o_req.wr_cnt      = cnt_upd;
                n_res.status      = STAT_OK;
                n_res.slot_index  = to_out_idx(r_idx);
                n_res.new_count   = cnt_upd;
                n_res.must_block  = (r_mode == MODE_WAIT) && (cnt_upd < 0);
                n_res.wake_waiter = (r_mode == MODE_POST) && (cnt_upd <= 0);
            end
            ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_valid    <= '0;
            r_pend     <= 1'b0;
            r_free_vld <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_valid    <= n_valid;
            r_pend     <= n_pend;
            r_free_vld <= n_free_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode  <= n_mode;
        r_key   <= n_key;
        r_init  <= n_init;
        r_idx   <= n_idx;
        r_addr  <= n_addr;
        r_paddr <= n_paddr;
        r_free  <= n_free;
        r_res   <= n_res;
    end

    assign o_busy     = (r_state != ST_IDLE);
    assign o_res_push = (r_state == ST_DONE) && i_res_free;
    assign o_res      = r_res;

endmodule

// ===== hdl/named_semaphore_table.sv =====
// Named semaphore table, one item at a time. Open and remove scan the slots in order at one
// slot a cycle until a name matches or the last slot is compared. Wait and post read the count,
// then update it and write it back; on a slot not in use they go straight to the result.
// The result register lets the next item be accepted while a result waits.
// Reset clears the valid bits and the sequencer; the memories keep no reset.
// Depends on nst_pkg, nst_store and nst_ctrl.
module named_semaphore_table (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  nst_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output nst_pkg::t_out o_out
);
    import nst_pkg::*;

    t_mem_req req;
    t_mem_rsp rsp;
    t_out     res;
    logic     res_push;
    logic     res_free;
    logic     busy;
    logic     r_out_vld;
    t_out     r_out;

    // The result register takes a new value when empty or being transferred.
    assign res_free = !r_out_vld || !i_out_stall;

    nst_store u_store (
        .i_clk (i_clk),
        .i_req (req),
        .o_rsp (rsp)
    );

    nst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in       (i_in),
        .o_busy     (busy),
        .i_res_free (res_free),
        .o_res_push (res_push),
        .o_res      (res),
        .o_req      (req),
        .i_rsp      (rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_push) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_push) begin
            r_out <= res;
        end
    end

    assign o_in_stall  = busy;
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

endmodule
